// ===== rtl/abps_pkg.sv =====
// package for the aabb body physics step block
`timescale 1ns / 1ps
package abps_pkg;
    localparam int MaxBodies = 16;
    localparam int IdxW      = $clog2(MaxBodies);
    localparam int CntW      = $clog2(MaxBodies + 1);

    typedef enum logic [1:0] {
        MODE_WRITE = 2'd0,
        MODE_STEP  = 2'd1,
        MODE_READ  = 2'd2,
        MODE_NONE  = 2'd3
    } t_mode;

    localparam int CfgBodyCount = 0;
    localparam int CfgGravity   = 1;

    localparam int KindDynamic  = 0;
    localparam int KindCollider = 1;
    localparam int KindGravity  = 2;

    typedef struct packed {
        logic [1:0]         mode;
        logic [3:0]         body_index;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic [30:0]        size_x;
        logic [30:0]        size_y;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic [2:0]         body_kind;
        logic [19:0]        delta;
        logic               focused;
    } t_in;

    typedef struct packed {
        logic signed [31:0] out_pos_x;
        logic signed [31:0] out_pos_y;
        logic signed [31:0] out_vel_x;
        logic signed [31:0] out_vel_y;
        logic [2:0]         out_kind;
        logic               step_done;
    } t_out;

    // front to back command after classification
    typedef struct packed {
        t_mode      mode;
        logic       idx_ok;
        logic       run;
        t_in        item;
    } t_cmd;

    typedef enum logic [3:0] {
        ST_IDLE, ST_BODY, ST_MULX, ST_ADDX, ST_RESX, ST_MULY, ST_ADDY,
        ST_RESY, ST_GRAV, ST_GADD, ST_OUT
    } t_state;

    function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
        if (v > 48'sd2147483647) return 32'sh7fffffff;
        if (v < -48'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    // floor of (a*b)>>16, a signed 32, b unsigned up to 31 bits
    function automatic logic signed [47:0] qshift(input logic signed [63:0] p);
        return p[63:16];
    endfunction
endpackage

// ===== rtl/abps_if.sv =====
// valid ready channel interface
`timescale 1ns / 1ps
interface abps_if #(parameter int W = 8);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/aabb_body_physics_step.sv =====
// top level of the aabb body physics step block
// write and read: a command leaves the queue via IDLE and OUT into the result register
// step: dynamic bodies scan all n bodies per moving axis (n clamped count)
// a two entry command queue lets input beats in while the back end works
// reset (synchronous, active low) clears control, configuration registers and queue; table undefined
`timescale 1ns / 1ps
module aabb_body_physics_step (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [30:0] i_cfg_data,
    abps_if.sink        in_ch,
    abps_if.source      out_ch
);
    import abps_pkg::*;
    logic [4:0]  r_body_count;
    logic [30:0] r_gravity;
    t_cmd        cmd;
    logic        cmd_valid;
    logic        cmd_pop;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_body_count <= '0;
            r_gravity    <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_index == 1'(CfgBodyCount)) r_body_count <= i_cfg_data[4:0];
            if (i_cfg_index == 1'(CfgGravity)) r_gravity <= i_cfg_data;
        end
    end

    abps_front u_front (
        .i_clk, .i_rst_n, .in_ch,
        .o_cmd(cmd), .o_cmd_valid(cmd_valid), .i_cmd_pop(cmd_pop)
    );

    abps_back u_back (
        .i_clk, .i_rst_n, .i_cmd(cmd), .i_cmd_valid(cmd_valid), .o_cmd_pop(cmd_pop),
        .i_body_count(r_body_count), .i_gravity(r_gravity), .out_ch
    );
endmodule

// ===== rtl/abps_front.sv =====
// front: accepts items, classifies them and queues commands
`timescale 1ns / 1ps
module abps_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    abps_if.sink              in_ch,
    output abps_pkg::t_cmd    o_cmd,
    output logic              o_cmd_valid,
    input  logic              i_cmd_pop
);
    import abps_pkg::*;
    // two entry queue
    t_cmd       r_q [2];
    logic [1:0] r_cnt;
    logic       r_rd;
    logic       r_wr;
    t_cmd       n_c;
    logic       push;
    logic       pop;

    assign in_ch.ready = (r_cnt != 2'd2);
    assign push = in_ch.valid && in_ch.ready;
    assign pop  = i_cmd_pop && (r_cnt != 2'd0);
    assign o_cmd = r_q[r_rd];
    assign o_cmd_valid = (r_cnt != 2'd0);

    always_comb begin
        n_c.item   = t_in'(in_ch.data);
        n_c.mode   = t_mode'(n_c.item.mode);
        n_c.idx_ok = ({1'b0, n_c.item.body_index} < (IdxW + 1)'(MaxBodies));
        n_c.run    = n_c.item.focused;
    end

    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wr] <= n_c;
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
        end else begin
            if (push) r_wr <= ~r_wr;
            if (pop) r_rd <= ~r_rd;
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n) r_cnt != 2'd3)
        else $error("queue count overflow");
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2 && !pop) |=> !in_ch.ready) else $error("full queue took beat");
    a_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0) |-> !o_cmd_valid) else $error("empty queue shows command");
endmodule

// ===== rtl/abps_back.sv =====
// back: body table and sequencer for write, read and step
`timescale 1ns / 1ps
module abps_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  abps_pkg::t_cmd  i_cmd,
    input  logic            i_cmd_valid,
    output logic            o_cmd_pop,
    input  logic [4:0]      i_body_count,
    input  logic [30:0]     i_gravity,
    abps_if.source          out_ch
);
    import abps_pkg::*;
    // table in flip-flops, read at the two sequencer indexes and at the command index
    logic signed [31:0] r_px [MaxBodies];
    logic signed [31:0] r_py [MaxBodies];
    logic [30:0]        r_ex [MaxBodies];
    logic [30:0]        r_ey [MaxBodies];
    logic signed [31:0] r_vx [MaxBodies];
    logic signed [31:0] r_vy [MaxBodies];
    logic [2:0]         r_kd [MaxBodies];

    t_state r_st, n_st;
    logic [IdxW-1:0] r_i, r_j;
    logic [CntW-1:0] r_n;
    logic [19:0]     r_dt;
    logic signed [63:0] r_prod;
    logic signed [31:0] r_v;
    logic            r_pos;
    logic            r_ovalid;
    t_out            r_out;
    t_out            n_out;
    logic            i_last, j_last, hit, grav;

    logic signed [33:0] ax0, ax1, bx0, bx1, ay0, ay1, by0, by1;
    logic signed [47:0] d;
    logic signed [33:0] snap;

    assign out_ch.valid = r_ovalid;
    assign out_ch.data  = r_out;
    assign o_cmd_pop = (r_st == ST_OUT) && !r_ovalid;

    assign i_last = ({1'b0, r_i} + 1'b1) >= r_n;
    assign j_last = ({1'b0, r_j} + 1'b1) >= r_n;
    assign grav = r_kd[r_i][KindGravity] && (i_gravity != '0);
    assign ax0 = 34'(r_px[r_i]);
    assign ax1 = ax0 + 34'({1'b0, r_ex[r_i]});
    assign bx0 = 34'(r_px[r_j]);
    assign bx1 = bx0 + 34'({1'b0, r_ex[r_j]});
    assign ay0 = 34'(r_py[r_i]);
    assign ay1 = ay0 + 34'({1'b0, r_ey[r_i]});
    assign by0 = 34'(r_py[r_j]);
    assign by1 = by0 + 34'({1'b0, r_ey[r_j]});
    assign hit = (r_j != r_i) && r_kd[r_j][KindCollider]
        && ax0 < bx1 && ax1 > bx0 && ay0 < by1 && ay1 > by0;
    assign d = qshift(r_prod);

    always_comb begin
        snap = '0;
        if (r_st == ST_RESX) snap = r_pos ? bx0 - 34'({1'b0, r_ex[r_i]}) : bx1;
        else snap = r_pos ? by0 - 34'({1'b0, r_ey[r_i]}) : by1;
    end

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            ST_IDLE: if (i_cmd_valid) begin
                n_st = ST_OUT;
                if (t_mode'(i_cmd.mode) == MODE_STEP && i_cmd.run && i_body_count != '0)
                    n_st = ST_BODY;
            end
            ST_BODY: begin
                if (!r_kd[r_i][KindDynamic]) n_st = i_last ? ST_OUT : ST_BODY;
                else if (r_vx[r_i] != '0) n_st = ST_MULX;
                else n_st = ST_MULY;
            end
            ST_MULX: n_st = ST_ADDX;
            ST_ADDX: n_st = ST_RESX;
            ST_RESX: if (j_last) n_st = ST_MULY;
            ST_MULY: n_st = (r_vy[r_i] != '0) ? ST_ADDY : ST_GRAV;
            ST_ADDY: n_st = ST_RESY;
            ST_RESY: if (j_last) n_st = ST_GRAV;
            ST_GRAV: n_st = grav ? ST_GADD : (i_last ? ST_OUT : ST_BODY);
            ST_GADD: n_st = i_last ? ST_OUT : ST_BODY;
            ST_OUT:  if (!r_ovalid) n_st = ST_IDLE;
            default: n_st = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        case (r_st)
            ST_IDLE: if (i_cmd_valid) begin
                r_dt <= i_cmd.item.delta;
                r_n  <= (i_body_count > 5'(MaxBodies)) ? CntW'(MaxBodies)
                                                      : CntW'(i_body_count);
                r_i  <= '0;
                r_j  <= '0;
                if (t_mode'(i_cmd.mode) == MODE_WRITE && i_cmd.idx_ok) begin
                    r_px[i_cmd.item.body_index[IdxW-1:0]] <= i_cmd.item.pos_x;
                    r_py[i_cmd.item.body_index[IdxW-1:0]] <= i_cmd.item.pos_y;
                    r_ex[i_cmd.item.body_index[IdxW-1:0]] <= i_cmd.item.size_x;
                    r_ey[i_cmd.item.body_index[IdxW-1:0]] <= i_cmd.item.size_y;
                    r_vx[i_cmd.item.body_index[IdxW-1:0]] <= i_cmd.item.vel_x;
                    r_vy[i_cmd.item.body_index[IdxW-1:0]] <= i_cmd.item.vel_y;
                    r_kd[i_cmd.item.body_index[IdxW-1:0]] <= i_cmd.item.body_kind;
                end
            end
            ST_BODY: if (!r_kd[r_i][KindDynamic]) r_i <= r_i + 1'b1;
            ST_MULX: begin
                r_v <= r_vx[r_i];
                r_prod <= 64'(r_vx[r_i]) * 64'({1'b0, r_dt});
            end
            ST_ADDX: begin
                r_px[r_i] <= sat32(48'(r_px[r_i]) + d);
                r_vx[r_i] <= sat32(48'(r_v) - d);
                r_pos <= (r_v > 0);
                r_j <= '0;
            end
            ST_RESX: begin
                if (hit) begin
                    r_px[r_i] <= sat32(48'(snap));
                    r_vx[r_i] <= '0;
                end
                r_j <= r_j + 1'b1;
            end
            ST_MULY: begin
                r_v <= r_vy[r_i];
                r_prod <= 64'(r_vy[r_i]) * 64'({1'b0, r_dt});
            end
            ST_ADDY: begin
                r_py[r_i] <= sat32(48'(r_py[r_i]) + d);
                if (!(r_v < 0 && grav)) r_vy[r_i] <= sat32(48'(r_v) - d);
                r_pos <= (r_v > 0);
                r_j <= '0;
                // downward gravity body: first gravity term follows
                r_prod <= 64'({1'b0, i_gravity}) * 64'({1'b0, r_dt});
            end
            ST_RESY: begin
                if (hit) begin
                    r_py[r_i] <= sat32(48'(snap));
                    r_vy[r_i] <= '0;
                end
                r_j <= r_j + 1'b1;
                // first gravity term lands before any later hit clears it
                if (r_j == '0 && r_v < 0 && grav && !hit)
                    r_vy[r_i] <= sat32(48'(r_v) - d);
            end
            ST_GRAV: begin
                r_prod <= 64'({1'b0, i_gravity}) * 64'({1'b0, r_dt});
                if (!grav) r_i <= r_i + 1'b1;
            end
            ST_GADD: begin
                r_vy[r_i] <= sat32(48'(r_vy[r_i]) - d);
                r_i <= r_i + 1'b1;
            end
            default: ;
        endcase
    end

    always_comb begin
        n_out = '0;
        if (t_mode'(i_cmd.mode) == MODE_STEP) n_out.step_done = 1'b1;
        if (t_mode'(i_cmd.mode) == MODE_READ && i_cmd.idx_ok) begin
            n_out.out_pos_x = r_px[i_cmd.item.body_index[IdxW-1:0]];
            n_out.out_pos_y = r_py[i_cmd.item.body_index[IdxW-1:0]];
            n_out.out_vel_x = r_vx[i_cmd.item.body_index[IdxW-1:0]];
            n_out.out_vel_y = r_vy[i_cmd.item.body_index[IdxW-1:0]];
            n_out.out_kind  = r_kd[i_cmd.item.body_index[IdxW-1:0]];
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= ST_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_st <= n_st;
            if (r_ovalid && out_ch.ready) r_ovalid <= 1'b0;
            else if (r_st == ST_OUT && !r_ovalid) r_ovalid <= 1'b1;
        end
        if (r_st == ST_OUT && !r_ovalid) r_out <= n_out;
    end

    a_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_pop |-> i_cmd_valid) else $error("pop without command");
    a_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == ST_RESX || r_st == ST_RESY) |-> {1'b0, r_j} < r_n)
        else $error("collider index past count");
    a_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_pop |=> r_ovalid) else $error("result not raised");
endmodule
